/* design/hset_pkg.sv */
// shared constants and types for the critical-edge tracker
`timescale 1ns / 1ps
package hset_pkg;
   localparam int NUM_VERTICES = 32;
   localparam int NUM_EDGES    = 64;
   localparam int MAX_LEVELS   = 32;
   localparam int VERT_W       = 5;
   localparam int LEVEL_W      = 5;
   localparam int CMD_W        = 3;
   localparam int COUNT_W      = 7;
   localparam int SET_W        = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT    = 3'd0,
      CMD_LOAD    = 3'd1,
      CMD_CHECK   = 3'd2,
      CMD_ADD     = 3'd3,
      CMD_RESTORE = 3'd4,
      CMD_RSVD5   = 3'd5,
      CMD_RSVD6   = 3'd6,
      CMD_RSVD7   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_EXEC = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   localparam logic [1:0] REG_EDGE_COUNT = 2'd0;

   // request and result beats
   typedef struct packed {
      cmd_type              command;
      logic [VERT_W-1:0]    vertex;
      logic [NUM_EDGES-1:0] row_data;
      logic [SET_W-1:0]     member_set;
      logic [LEVEL_W-1:0]   level;
   } search_req_type;

   typedef struct packed {
      logic                 violates;
      logic [NUM_EDGES-1:0] uncovered;
      logic                 all_covered;
      logic                 error;
   } search_rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                  clear;      // init: zero critical row
      logic                  add;        // add: strip hit, write overlay
      logic                  restore;    // restore: or overlay in
      logic                  set_own;    // write own critical row (added vertex)
      logic                  zero_own;   // clear own critical row (restored vertex)
      logic [VERT_W-1:0]     vertex;
      logic [SET_W-1:0]      members;
      logic [NUM_EDGES-1:0]  hit;
      logic [NUM_EDGES-1:0]  own_value;
      logic [NUM_EDGES-1:0]  test;
   } cell_ctl_type;

   function automatic logic [NUM_EDGES-1:0] edge_mask(input logic [COUNT_W-1:0] n);
      logic [NUM_EDGES-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_EDGES; i++) begin
         if (COUNT_W'(i) < n) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction
endpackage

/* design/hset_if.sv */
// valid/ready channel carrying a payload
`timescale 1ns / 1ps
interface hset_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/hitting_set_critical_edge_tracker.sv */
// top level: sequencer, chain of vertex cells, configuration register
`timescale 1ns / 1ps
// Critical-edge tracker for a hitting-set search.
// Input channel req carries command, vertex, row_data, member_set and level;
// result channel rsp carries violates, uncovered, all_covered and error, one
// beat per request beat. csr is an APB-style port holding edge_count at 0x0.
// Each request passes through capture, incidence memory and overlay
// read, then the execute step where every vertex cell updates its critical
// row in parallel and the violation flag ripples along the cell chain.
// The result is written to an output register by the execute step; the next
// request is taken in the cycle after the result has been delivered.
// Reset clears all critical rows, sets the uncovered set to all edges and
// edge_count to 64; incidence rows and overlays hold nothing until written.
// A stalled receiver holds the result and keeps req_ready low until taken.
// Vertex and level fields cover exactly the 32 vertices and 32 levels.
module hitting_set_critical_edge_tracker (
   input  logic        clock,
   input  logic        reset,
   hset_if.sink        req,
   hset_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int N = hset_pkg::NUM_VERTICES;
   logic [hset_pkg::COUNT_W-1:0] count_ff;
   hset_pkg::cell_ctl_type       ctl;
   logic [hset_pkg::LEVEL_W-1:0] level;
   logic [N:0]                   viol;
   logic [hset_pkg::NUM_EDGES-1:0] crit [N];

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == hset_pkg::REG_EDGE_COUNT) ?
                       {25'd0, count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd64;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == hset_pkg::REG_EDGE_COUNT) begin
         count_ff <= csr_pwdata[6:0];
      end
   end

   hset_seq u_seq (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_command(req.payload.command), .req_vertex(req.payload.vertex),
      .req_row_data(req.payload.row_data), .req_member_set(req.payload.member_set),
      .req_level(req.payload.level),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_violates(rsp.payload.violates), .rsp_uncovered(rsp.payload.uncovered),
      .rsp_all_covered(rsp.payload.all_covered), .rsp_error(rsp.payload.error),
      .edge_count(count_ff), .ctl, .level,
      .violation(viol[N]), .own_crit(crit[ctl.vertex])
   );

   assign viol[0] = 1'b0;
   for (genvar i = 0; i < N; i++) begin : g_cell
      hset_cell u_cell (
         .clock, .reset,
         .index(hset_pkg::VERT_W'(i)), .ctl, .level,
         .viol_chain(viol[i]), .viol_out(viol[i+1]),
         .crit_out(crit[i])
      );
   end
endmodule

/* design/hset_cell.sv */
// one vertex cell: critical row, violation flag, undo overlays for all levels
`timescale 1ns / 1ps
module hset_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hset_pkg::VERT_W-1:0]         index,
   input  hset_pkg::cell_ctl_type              ctl,
   input  logic [hset_pkg::LEVEL_W-1:0]        level,
   input  logic                                viol_chain,
   output logic                                viol_out,
   output logic [hset_pkg::NUM_EDGES-1:0]      crit_out
);
   logic [hset_pkg::NUM_EDGES-1:0] crit_ff, crit_in;
   logic [hset_pkg::NUM_EDGES-1:0] overlay_mem [hset_pkg::MAX_LEVELS];
   logic [hset_pkg::NUM_EDGES-1:0] overlay_rd_ff;
   logic member;
   logic own;

   assign member = ctl.members[index];
   assign own    = (ctl.vertex == index);
   // violation ripples along the row; each cell or-s its own term
   assign viol_out = viol_chain | (member & ((crit_ff & ~ctl.test) == '0));
   assign crit_out = crit_ff;

   always_comb begin
      crit_in = crit_ff;
      priority if (ctl.clear) begin
         crit_in = '0;
      end else if (ctl.add) begin
         if (own && ctl.set_own) begin
            crit_in = ctl.own_value;
         end else if (member) begin
            crit_in = crit_ff & ~ctl.hit;
         end
      end else if (ctl.restore) begin
         if (own && ctl.zero_own) begin
            crit_in = '0;
         end else if (member) begin
            crit_in = crit_ff | overlay_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_ff <= '0;
      end else begin
         crit_ff <= crit_in;
      end
   end

   always_ff @(posedge clock) begin
      overlay_rd_ff <= overlay_mem[level];
      if (ctl.add) begin
         overlay_mem[level] <= member ? (crit_ff & ctl.hit) : '0;
      end
   end
endmodule

/* design/hset_seq.sv */
// command sequencer: decode, incidence memory, uncovered set, result register
`timescale 1ns / 1ps
module hset_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hset_pkg::CMD_W-1:0]        req_command,
   input  logic [hset_pkg::VERT_W-1:0]       req_vertex,
   input  logic [hset_pkg::NUM_EDGES-1:0]    req_row_data,
   input  logic [hset_pkg::SET_W-1:0]        req_member_set,
   input  logic [hset_pkg::LEVEL_W-1:0]      req_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_violates,
   output logic [hset_pkg::NUM_EDGES-1:0]    rsp_uncovered,
   output logic                              rsp_all_covered,
   output logic                              rsp_error,
   input  logic [hset_pkg::COUNT_W-1:0]      edge_count,
   output hset_pkg::cell_ctl_type            ctl,
   output logic [hset_pkg::LEVEL_W-1:0]      level,
   input  logic                              violation,
   input  logic [hset_pkg::NUM_EDGES-1:0]    own_crit
);
   hset_pkg::state_type state_ff, state_in;
   logic [hset_pkg::CMD_W-1:0]     cmd_ff;
   logic [hset_pkg::VERT_W-1:0]    vert_ff;
   logic [hset_pkg::NUM_EDGES-1:0] row_ff;
   logic [hset_pkg::SET_W-1:0]     set_ff;
   logic [hset_pkg::LEVEL_W-1:0]   lvl_ff;
   logic [hset_pkg::NUM_EDGES-1:0] unc_ff, unc_in;
   logic [hset_pkg::NUM_EDGES-1:0] inc_mem [hset_pkg::NUM_VERTICES];
   logic [hset_pkg::NUM_EDGES-1:0] inc_rd_ff;
   logic                           out_valid_ff;
   logic                           out_viol_ff, out_err_ff;
   logic [hset_pkg::NUM_EDGES-1:0] out_unc_ff;
   logic                           accept, exec, err, is_member;
   logic                           do_clear, do_add, do_restore, do_load;
   logic [hset_pkg::NUM_EDGES-1:0] mask;

   assign accept = req_valid & req_ready;
   assign mask   = hset_pkg::edge_mask(edge_count);
   assign is_member = set_ff[vert_ff];
   assign level  = lvl_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hset_pkg::ST_IDLE: if (accept) state_in = hset_pkg::ST_READ;
         hset_pkg::ST_READ: state_in = hset_pkg::ST_EXEC;
         hset_pkg::ST_EXEC: state_in = hset_pkg::ST_DONE;
         hset_pkg::ST_DONE: if (!out_valid_ff || rsp_ready) state_in = hset_pkg::ST_IDLE;
         default: state_in = hset_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      exec      = 1'b0;
      unique case (state_ff)
         hset_pkg::ST_IDLE: req_ready = 1'b1;
         hset_pkg::ST_EXEC: exec = 1'b1;
         default: ;
      endcase
   end

   // precondition check, valid in the execute step
   always_comb begin
      err = 1'b0;
      unique case (hset_pkg::cmd_type'(cmd_ff))
         hset_pkg::CMD_INIT:  err = 1'b0;
         hset_pkg::CMD_LOAD:  err = 1'b0;
         hset_pkg::CMD_CHECK: err = is_member || (own_crit != '0);
         hset_pkg::CMD_ADD:   err = is_member || (own_crit != '0);
         hset_pkg::CMD_RESTORE: err = is_member || ((unc_ff & own_crit) != '0);
         default: err = 1'b1;
      endcase
   end

   assign do_clear   = exec && (cmd_ff == hset_pkg::CMD_INIT);
   assign do_load    = exec && (cmd_ff == hset_pkg::CMD_LOAD);
   assign do_add     = exec && !err && (cmd_ff == hset_pkg::CMD_ADD);
   assign do_restore = exec && !err && (cmd_ff == hset_pkg::CMD_RESTORE);

   always_comb begin
      ctl.clear     = do_clear;
      ctl.add       = do_add;
      ctl.restore   = do_restore;
      ctl.set_own   = do_add;
      ctl.zero_own  = do_restore;
      ctl.vertex    = vert_ff;
      ctl.members   = set_ff;
      ctl.hit       = inc_rd_ff;
      ctl.own_value = inc_rd_ff & unc_ff;
      ctl.test      = inc_rd_ff & ~unc_ff;
   end

   always_comb begin
      unc_in = unc_ff;
      priority if (do_clear) begin
         unc_in = mask;
      end else if (do_add) begin
         unc_in = unc_ff & ~inc_rd_ff;
      end else if (do_restore) begin
         unc_in = unc_ff | own_crit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hset_pkg::ST_IDLE;
         unc_ff       <= {hset_pkg::NUM_EDGES{1'b1}};
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unc_ff   <= unc_in;
         if (exec) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         vert_ff <= req_vertex;
         row_ff  <= req_row_data;
         set_ff  <= req_member_set;
         lvl_ff  <= req_level;
      end
      inc_rd_ff <= inc_mem[vert_ff];
      if (do_load) begin
         inc_mem[vert_ff] <= row_ff & mask;
      end
      if (exec) begin
         out_viol_ff <= !err && (cmd_ff == hset_pkg::CMD_CHECK) && violation;
         out_err_ff  <= err;
         out_unc_ff  <= unc_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_violates    = out_viol_ff;
   assign rsp_uncovered   = out_unc_ff;
   assign rsp_all_covered = (out_unc_ff == '0);
   assign rsp_error       = out_err_ff;
endmodule

/* design/hset_checker.sv */
// port-level checks for the tracker, bound to the top level
`timescale 1ns / 1ps
module hset_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        viol,
   input logic        err,
   input logic        allc,
   input logic [63:0] unc
);
   a_cov: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (allc == (unc == 64'd0))) else $error("all_covered mismatch");
   a_viol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err |-> !viol) else $error("violates with error");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("back to back accept");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("beat dropped");
endmodule

bind hitting_set_critical_edge_tracker hset_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .viol(rsp.payload.violates), .err(rsp.payload.error),
   .allc(rsp.payload.all_covered), .unc(rsp.payload.uncovered)
);
